[hw/rtl/fit_policy_segment_allocator_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef FIT_POLICY_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPSA_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPSA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fpsa_pkg.sv]
`default_nettype none
package fpsa_pkg;

	localparam int MAX_CHUNKS_DEF = 16;
	localparam int ADDR_BITS_DEF  = 16;
	localparam int SIZE_W         = 16;
	localparam int NEED_W         = SIZE_W + 1;
	localparam int HDR_BYTES      = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam logic [SIZE_W-1:0] POOL_RESET = 16'd4096;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_ADDR  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

	typedef struct packed {
		logic load;
		logic rd_free;
		logic rd_used;
		logic alloc_cmt;
		logic free_cmt;
		logic addr_err;
		logic rsp_load;
	} fpsa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic addr_zero;
		logic u_found;
		logic rsp_busy;
	} fpsa_stat_t;

endpackage
`default_nettype wire

[hw/rtl/fpsa_if.sv]
`default_nettype none
interface fpsa_req_if import fpsa_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] req_size;
	logic [15:0] user_addr;
	modport source(output valid, func, req_size, user_addr, input ready);
	modport sink(input valid, func, req_size, user_addr, output ready);
endinterface

interface fpsa_rsp_if import fpsa_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] granted_addr;
	logic [15:0] free_bytes;
	modport source(output valid, status, granted_addr, free_bytes, input ready);
	modport sink(input valid, status, granted_addr, free_bytes, output ready);
endinterface

interface fpsa_cfg_if import fpsa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/fpsa_ram.sv]
`default_nettype none
module fpsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/fpsa_ctrl.sv]
`default_nettype none
module fpsa_ctrl import fpsa_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire fpsa_stat_t                    st,
	output      fpsa_cmd_t                     cmd,
	output      logic [$clog2(MAX_CHUNKS)-1:0] rd_idx
);
	localparam int IDX_W = $clog2(MAX_CHUNKS);
	localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_ASCAN   = 3'd2;
	localparam logic [2:0] S_ACMT    = 3'd3;
	localparam logic [2:0] S_USCAN   = 3'd4;
	localparam logic [2:0] S_UCHK    = 3'd5;
	localparam logic [2:0] S_FSCAN   = 3'd6;
	localparam logic [2:0] S_FCMT_D  = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             cnt_end;
	logic             done_q, done_d;

	assign cnt_end = (cnt_q == CNT_W'(MAX_CHUNKS));
	assign rd_idx  = cnt_q[IDX_W-1:0];

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		done_d   = done_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (done_q) begin
					// hold the result until the output register is free
					if (!st.rsp_busy) begin
						cmd.rsp_load = 1'b1;
						done_d       = 1'b0;
					end
				end else begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_DECODE;
					end
				end
			end
			S_DECODE: begin
				cnt_d = '0;
				if (!st.is_free) begin
					state_d = S_ASCAN;
				end else if (st.addr_zero) begin
					cmd.addr_err = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_USCAN;
				end
			end
			S_ASCAN, S_USCAN, S_FSCAN: begin
				if (cnt_end) begin
					cnt_d = '0;
					case (state_q)
						S_ASCAN: state_d = S_ACMT;
						S_USCAN: state_d = S_UCHK;
						default: state_d = S_FCMT_D;
					endcase
				end else begin
					cmd.rd_free = (state_q != S_USCAN);
					cmd.rd_used = (state_q == S_USCAN);
					cnt_d       = cnt_q + CNT_W'(1);
				end
			end
			S_ACMT: begin
				cmd.alloc_cmt = 1'b1;
				done_d        = 1'b1;
				state_d       = S_IDLE;
			end
			S_UCHK: begin
				if (st.u_found) begin
					state_d = S_FSCAN;
				end else begin
					cmd.addr_err = 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_FCMT_D: begin
				cmd.free_cmt = 1'b1;
				done_d       = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/fpsa_dp.sv]
`default_nettype none
module fpsa_dp import fpsa_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fpsa_cmd_t                     cmd,
	input  wire logic [$clog2(MAX_CHUNKS)-1:0] rd_idx,
	output      fpsa_stat_t                    st,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                          in_func,
	input  wire logic [15:0]                   in_req_size,
	input  wire logic [15:0]                   in_user_addr,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [1:0]                    out_status,
	output      logic [15:0]                   out_granted_addr,
	output      logic [15:0]                   out_free_bytes
);
	localparam int IDX_W   = $clog2(MAX_CHUNKS);
	localparam int ENTRY_W = ADDR_BITS + SIZE_W;

	// configuration and pool state
	logic [1:0]            fit_mode_q;
	logic [SIZE_W-1:0]     pool_size_q;
	logic [MAX_CHUNKS-1:0] free_vld_q, used_vld_q;
	logic                  init0_q;
	logic [SIZE_W-1:0]     free_total_q;

	// operation registers
	logic                  func_q;
	logic [NEED_W-1:0]     need_q;
	logic [15:0]           uaddr_q;

	// table read stage
	logic                  ev_free_s1, ev_used_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [ENTRY_W-1:0]    frd, urd;
	logic [ADDR_BITS-1:0]  f_addr, u_addr;
	logic [SIZE_W-1:0]     f_size, u_size;
	logic                  f_vld, u_vld;

	// scan trackers
	logic                  pk_found_q;
	logic [IDX_W-1:0]      pk_idx_q;
	logic [ADDR_BITS-1:0]  pk_addr_q;
	logic [SIZE_W-1:0]     pk_size_q;
	logic                  uslot_found_q, fslot_found_q;
	logic [IDX_W-1:0]      uslot_q, fslot_q;
	logic                  u_found_q;
	logic [IDX_W-1:0]      u_idx_q;
	logic [ADDR_BITS-1:0]  h_q;
	logic [SIZE_W-1:0]     sz_q;
	logic                  prev_found_q, next_found_q;
	logic [IDX_W-1:0]      prev_idx_q, next_idx_q;
	logic [ADDR_BITS-1:0]  prev_addr_q;
	logic [SIZE_W-1:0]     prev_size_q, next_size_q;

	// result staging and output register
	logic [1:0]            res_status_q;
	logic [15:0]           res_granted_q;
	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [15:0]           out_granted_q, out_free_q;

	// evaluation helpers
	logic                  consider, better, u_match;
	logic [ADDR_BITS-1:0]  f_end, end_h, u_user;

	// commit logic
	logic                  a_fits, split;
	logic [NEED_W-1:0]     rem;
	logic [SIZE_W-1:0]     usize;
	logic                  fram_we, uram_we;
	logic [IDX_W-1:0]      fram_widx, uram_widx;
	logic [ENTRY_W-1:0]    fram_wdata, uram_wdata;
	logic                  fvld_set, fvld_clr, uvld_set, uvld_clr;
	logic [IDX_W-1:0]      fvld_set_idx, fvld_clr_idx;
	logic [1:0]            res_status_d;
	logic [15:0]           res_granted_d;
	logic [SIZE_W-1:0]     total_d;
	logic                  pool_wr;

	fpsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CHUNKS)) u_fram (
		.clk(clk), .we(fram_we), .waddr(fram_widx), .wdata(fram_wdata),
		.re(cmd.rd_free), .raddr(rd_idx), .rdata_q(frd)
	);

	fpsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CHUNKS)) u_uram (
		.clk(clk), .we(uram_we), .waddr(uram_widx), .wdata(uram_wdata),
		.re(cmd.rd_used), .raddr(rd_idx), .rdata_q(urd)
	);

	assign pool_wr = cfg_we && (cfg_index == CFG_POOL_SIZE);

	// entry 0 reads as the whole pool until it is first written
	always_comb begin
		if (init0_q && (idx_s1 == '0)) begin
			f_addr = '0;
			f_size = pool_size_q;
		end else begin
			f_addr = frd[ENTRY_W-1:SIZE_W];
			f_size = frd[SIZE_W-1:0];
		end
	end
	assign u_addr = urd[ENTRY_W-1:SIZE_W];
	assign u_size = urd[SIZE_W-1:0];
	assign f_vld  = free_vld_q[idx_s1];
	assign u_vld  = used_vld_q[idx_s1];

	assign f_end  = ADDR_BITS'(33'(f_addr) + 33'(f_size));
	assign end_h  = ADDR_BITS'(33'(h_q) + 33'(sz_q));
	assign u_user = ADDR_BITS'(33'(u_addr) + 33'(HDR_BYTES));
	assign u_match = u_vld && (32'(u_user) == 32'(uaddr_q));

	assign consider = f_vld && ((fit_mode_q == FIT_WORST) || ({1'b0, f_size} >= need_q));
	always_comb begin
		if ((fit_mode_q == FIT_BEST) && (f_size != pk_size_q)) begin
			better = (f_size < pk_size_q);
		end else if ((fit_mode_q == FIT_WORST) && (f_size != pk_size_q)) begin
			better = (f_size > pk_size_q);
		end else begin
			better = (f_addr < pk_addr_q);
		end
	end

	assign a_fits = pk_found_q && ({1'b0, pk_size_q} >= need_q);
	assign rem    = {1'b0, pk_size_q} - need_q;
	assign split  = (rem > NEED_W'(HDR_BYTES));
	assign usize  = split ? need_q[SIZE_W-1:0] : pk_size_q;

	always_comb begin
		fram_we       = 1'b0;
		fram_widx     = pk_idx_q;
		fram_wdata    = '0;
		uram_we       = 1'b0;
		uram_widx     = uslot_q;
		uram_wdata    = {pk_addr_q, usize};
		fvld_set      = 1'b0;
		fvld_set_idx  = fslot_q;
		fvld_clr      = 1'b0;
		fvld_clr_idx  = pk_idx_q;
		uvld_set      = 1'b0;
		uvld_clr      = 1'b0;
		res_status_d  = ST_OK;
		res_granted_d = '0;
		total_d       = free_total_q;
		if (cmd.alloc_cmt) begin
			if (!a_fits) begin
				res_status_d = ST_NOFIT;
			end else if (!uslot_found_q) begin
				res_status_d = ST_FULL;
			end else begin
				uram_we  = 1'b1;
				uvld_set = 1'b1;
				if (split) begin
					fram_we    = 1'b1;
					fram_wdata = {ADDR_BITS'(33'(pk_addr_q) + 33'(need_q)),
						rem[SIZE_W-1:0]};
				end else begin
					fvld_clr = 1'b1;
				end
				total_d       = free_total_q - usize;
				res_granted_d = 16'(32'(pk_addr_q) + 32'(HDR_BYTES));
			end
		end else if (cmd.free_cmt) begin
			if (!prev_found_q && !next_found_q && !fslot_found_q) begin
				res_status_d = ST_FULL;
			end else begin
				fram_we  = 1'b1;
				uvld_clr = 1'b1;
				total_d  = free_total_q + sz_q;
				if (prev_found_q && next_found_q) begin
					fram_widx    = prev_idx_q;
					fram_wdata   = {prev_addr_q, SIZE_W'(prev_size_q + sz_q + next_size_q)};
					fvld_clr     = 1'b1;
					fvld_clr_idx = next_idx_q;
				end else if (prev_found_q) begin
					fram_widx  = prev_idx_q;
					fram_wdata = {prev_addr_q, SIZE_W'(prev_size_q + sz_q)};
				end else if (next_found_q) begin
					fram_widx  = next_idx_q;
					fram_wdata = {h_q, SIZE_W'(next_size_q + sz_q)};
				end else begin
					fram_widx  = fslot_q;
					fram_wdata = {h_q, sz_q};
					fvld_set   = 1'b1;
				end
			end
		end else if (cmd.addr_err) begin
			res_status_d = ST_ADDR;
		end
	end

	// configuration, table valid bits and pool total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= FIT_FIRST;
			pool_size_q  <= POOL_RESET;
			free_vld_q   <= MAX_CHUNKS'(1);
			used_vld_q   <= '0;
			init0_q      <= 1'b1;
			free_total_q <= POOL_RESET;
		end else if (pool_wr) begin
			pool_size_q  <= cfg_data;
			free_vld_q   <= MAX_CHUNKS'(1);
			used_vld_q   <= '0;
			init0_q      <= 1'b1;
			free_total_q <= cfg_data;
		end else begin
			if (cfg_we && (cfg_index == CFG_FIT_MODE)) begin
				fit_mode_q <= cfg_data[1:0];
			end
			if (fvld_clr) begin
				free_vld_q[fvld_clr_idx] <= 1'b0;
			end
			if (fvld_set) begin
				free_vld_q[fvld_set_idx] <= 1'b1;
			end
			if (uvld_set) begin
				used_vld_q[uslot_q] <= 1'b1;
			end
			if (uvld_clr) begin
				used_vld_q[u_idx_q] <= 1'b0;
			end
			if (fram_we && (fram_widx == '0)) begin
				init0_q <= 1'b0;
			end
			free_total_q <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_free_s1 <= 1'b0;
			ev_used_s1 <= 1'b0;
		end else begin
			ev_free_s1 <= cmd.rd_free;
			ev_used_s1 <= cmd.rd_used;
		end
	end

	// scan evaluation, one table entry per cycle
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
		if (cmd.load) begin
			func_q        <= in_func;
			need_q        <= NEED_W'(in_req_size) + NEED_W'(HDR_BYTES);
			uaddr_q       <= in_user_addr;
			pk_found_q    <= 1'b0;
			uslot_found_q <= 1'b0;
			fslot_found_q <= 1'b0;
			u_found_q     <= 1'b0;
			prev_found_q  <= 1'b0;
			next_found_q  <= 1'b0;
		end else if (ev_free_s1 || ev_used_s1) begin
			if (!uslot_found_q && !u_vld) begin
				uslot_found_q <= 1'b1;
				uslot_q       <= idx_s1;
			end
			if (!fslot_found_q && !f_vld) begin
				fslot_found_q <= 1'b1;
				fslot_q       <= idx_s1;
			end
			if (ev_used_s1) begin
				if (!u_found_q && u_match) begin
					u_found_q <= 1'b1;
					u_idx_q   <= idx_s1;
					h_q       <= u_addr;
					sz_q      <= u_size;
				end
			end else if (func_q == FUNC_ALLOC) begin
				if (consider && (!pk_found_q || better)) begin
					pk_found_q <= 1'b1;
					pk_idx_q   <= idx_s1;
					pk_addr_q  <= f_addr;
					pk_size_q  <= f_size;
				end
			end else if (f_vld) begin
				if ((f_end == h_q) && !prev_found_q) begin
					prev_found_q <= 1'b1;
					prev_idx_q   <= idx_s1;
					prev_addr_q  <= f_addr;
					prev_size_q  <= f_size;
				end else if ((f_addr == end_h) && !next_found_q) begin
					next_found_q <= 1'b1;
					next_idx_q   <= idx_s1;
					next_size_q  <= f_size;
				end
			end
		end
		if (cmd.alloc_cmt || cmd.free_cmt || cmd.addr_err) begin
			res_status_q  <= res_status_d;
			res_granted_q <= res_granted_d;
		end
		if (cmd.rsp_load) begin
			out_status_q  <= res_status_q;
			out_granted_q <= res_granted_q;
			out_free_q    <= free_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_granted_addr = out_granted_q;
	assign out_free_bytes   = out_free_q;

	assign st.is_free   = (func_q == FUNC_FREE);
	assign st.addr_zero = (uaddr_q == '0);
	assign st.u_found   = u_found_q;
	assign st.rsp_busy  = out_valid_q && !out_ready;
endmodule
`default_nettype wire

[hw/rtl/fit_policy_segment_allocator_unit.sv]
`default_nettype none
// Segment allocator over a byte pool with first, best or worst fit placement.
// One operation is in work at a time. The scans read the free and
// used tables one entry per cycle through a single read port. A finished
// result sits in an output register. The next request can be taken in the
// same cycle as the result appears, while the result waits to be taken. A
// result that is still stalled in the output register holds the next result
// off. Configuration is always ready. A pool_size write restarts the pool as
// one free chunk.
module fit_policy_segment_allocator_unit import fpsa_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	fpsa_req_if.sink    req,
	fpsa_rsp_if.source  rsp,
	fpsa_cfg_if.sink    cfg
);
	fpsa_cmd_t                     cmd;
	fpsa_stat_t                    st;
	logic [$clog2(MAX_CHUNKS)-1:0] rd_idx;
	logic                          in_ready;

	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	fpsa_ctrl #(.MAX_CHUNKS(MAX_CHUNKS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(in_ready),
		.st(st), .cmd(cmd), .rd_idx(rd_idx)
	);

	fpsa_dp #(.MAX_CHUNKS(MAX_CHUNKS), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .rd_idx(rd_idx), .st(st),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.in_func(req.func), .in_req_size(req.req_size), .in_user_addr(req.user_addr),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.out_status(rsp.status), .out_granted_addr(rsp.granted_addr),
		.out_free_bytes(rsp.free_bytes)
	);
endmodule
`default_nettype wire

[hw/rtl/fpsa_checker.sv]
`default_nettype none
`include "fit_policy_segment_allocator_unit_assert.svh"
module fpsa_checker import fpsa_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  rsp_status,
	input wire logic [15:0] rsp_granted_addr,
	input wire logic [15:0] rsp_free_bytes
);
	// a stalled result beat holds
	`FPSA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_addr) && $stable(rsp_free_bytes), "result beat changed while stalled")

	// a failed operation grants nothing
	`FPSA_ASSERT_SAME(a_fail_zero, clk, arst_n, rsp_valid && (rsp_status != ST_OK), rsp_granted_addr == 16'd0, "failed operation with nonzero grant")

	// one request in work at a time
	`FPSA_ASSERT_NEXT(a_one_item, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")
endmodule

bind fit_policy_segment_allocator_unit fpsa_checker u_fpsa_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.status), .rsp_granted_addr(rsp.granted_addr),
	.rsp_free_bytes(rsp.free_bytes)
);
`default_nettype wire

[tb/sv/fit_policy_segment_allocator_unit_tb.sv]
`timescale 1ns / 100ps
module fit_policy_segment_allocator_unit_tb;
	import fpsa_pkg::*;

	typedef struct packed {
		logic        func;
		logic [15:0] req_size;
		logic [15:0] user_addr;
	} op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_addr;
		logic [15:0] free_bytes;
	} outcome_t;

	typedef struct {
		bit          valid;
		logic [15:0] addr;
		logic [16:0] size;
	} chunk_t;

	localparam int NCH = MAX_CHUNKS_DEF;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpsa_req_if req_bus();
	fpsa_rsp_if rsp_bus();
	fpsa_cfg_if cfg_bus();

	fit_policy_segment_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req_bus.sink), .rsp(rsp_bus.source),
		.cfg(cfg_bus.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	chunk_t     free_list[NCH];
	chunk_t     used_chunks[NCH];
	logic [15:0] free_sum;
	logic [1:0]  mode;
	logic [15:0] pool;

	op_t        pending_ops[$];
	outcome_t   expected_outcomes[$];
	logic [15:0] live_grants[$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  mismatches = 0;
	int  ops_sent = 0;
	int  outcomes_seen = 0;
	int  oks = 0;
	bit  req_acc = 1'b0;
	longint cycles = 0;

	function automatic void pool_reset();
		for (int i = 0; i < NCH; i++) begin
			free_list[i].valid = 0;
			used_chunks[i].valid = 0;
			free_list[i].addr = '0;
			free_list[i].size = '0;
			used_chunks[i].addr = '0;
			used_chunks[i].size = '0;
		end
		free_list[0].valid = 1;
		free_list[0].size = {1'b0, pool};
		free_sum = pool;
		live_grants.delete();
	endfunction

	function automatic bit prefers(chunk_t a, chunk_t b);
		if (mode == FIT_BEST && a.size != b.size)
			return a.size < b.size;
		if (mode == FIT_WORST && a.size != b.size)
			return a.size > b.size;
		return a.addr < b.addr;
	endfunction

	function automatic int first_empty(bit from_used);
		for (int i = 0; i < NCH; i++)
			if (!(from_used ? used_chunks[i].valid : free_list[i].valid))
				return i;
		return -1;
	endfunction

	function automatic outcome_t allocate(logic [15:0] n);
		outcome_t o;
		logic [16:0] need;
		logic [16:0] rem;
		int pick, top, slot;
		need = {1'b0, n} + 17'(HDR_BYTES);
		pick = -1;
		top = -1;
		o = '0;
		for (int i = 0; i < NCH; i++)
			if (free_list[i].valid && (top < 0 || prefers(free_list[i], free_list[top])))
				top = i;
		if (mode == FIT_WORST) begin
			if (top >= 0 && free_list[top].size >= need)
				pick = top;
		end else begin
			for (int i = 0; i < NCH; i++)
				if (free_list[i].valid && free_list[i].size >= need &&
						(pick < 0 || prefers(free_list[i], free_list[pick])))
					pick = i;
		end
		o.free_bytes = free_sum;
		if (pick < 0) begin
			o.status = ST_NOFIT;
			return o;
		end
		slot = first_empty(1'b1);
		if (slot < 0) begin
			o.status = ST_FULL;
			return o;
		end
		rem = free_list[pick].size - need;
		used_chunks[slot].valid = 1;
		used_chunks[slot].addr = free_list[pick].addr;
		if (rem > 17'(HDR_BYTES)) begin
			used_chunks[slot].size = need;
			free_list[pick].addr = free_list[pick].addr + need[15:0];
			free_list[pick].size = rem;
		end else begin
			used_chunks[slot].size = free_list[pick].size;
			free_list[pick].valid = 0;
		end
		free_sum = free_sum - used_chunks[slot].size[15:0];
		o.status = ST_OK;
		o.granted_addr = used_chunks[slot].addr + 16'(HDR_BYTES);
		o.free_bytes = free_sum;
		return o;
	endfunction

	function automatic outcome_t release_block(logic [15:0] ua);
		outcome_t o;
		int u, prv, nxt, slot;
		logic [15:0] h, fin;
		logic [16:0] sz;
		o = '0;
		o.free_bytes = free_sum;
		o.status = ST_ADDR;
		u = -1;
		prv = -1;
		nxt = -1;
		if (ua == 16'd0)
			return o;
		for (int i = 0; i < NCH; i++)
			if (u < 0 && used_chunks[i].valid && used_chunks[i].addr + 16'(HDR_BYTES) == ua)
				u = i;
		if (u < 0)
			return o;
		h = used_chunks[u].addr;
		sz = used_chunks[u].size;
		fin = h + sz[15:0];
		for (int i = 0; i < NCH; i++) begin
			if (!free_list[i].valid)
				continue;
			if (16'(free_list[i].addr + free_list[i].size[15:0]) == h && prv < 0)
				prv = i;
			else if (free_list[i].addr == fin && nxt < 0)
				nxt = i;
		end
		if (prv >= 0 && nxt >= 0) begin
			free_list[prv].size = free_list[prv].size + sz + free_list[nxt].size;
			free_list[nxt].valid = 0;
		end else if (prv >= 0) begin
			free_list[prv].size = free_list[prv].size + sz;
		end else if (nxt >= 0) begin
			free_list[nxt].addr = h;
			free_list[nxt].size = free_list[nxt].size + sz;
		end else begin
			slot = first_empty(1'b0);
			if (slot < 0) begin
				o.status = ST_FULL;
				return o;
			end
			free_list[slot].valid = 1;
			free_list[slot].addr = h;
			free_list[slot].size = sz;
		end
		used_chunks[u].valid = 0;
		free_sum = free_sum + sz[15:0];
		o.status = ST_OK;
		o.free_bytes = free_sum;
		return o;
	endfunction

	// driver: fed from pending_ops; the prediction is made at acceptance
	initial begin
		req_bus.valid = 1'b0;
		req_bus.func = FUNC_ALLOC;
		req_bus.req_size = '0;
		req_bus.user_addr = '0;
		rsp_bus.ready = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && !req_acc) begin
				// hold until accepted
			end else if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_bus.valid <= 1'b1;
				req_bus.func <= pending_ops[0].func;
				req_bus.req_size <= pending_ops[0].req_size;
				req_bus.user_addr <= pending_ops[0].user_addr;
				void'(pending_ops.pop_front());
			end else begin
				req_bus.valid <= 1'b0;
			end
			rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		outcome_t got, want;
		cycles <= cycles + 1;
		req_acc <= arst_n && req_bus.valid && req_bus.ready;
		if (arst_n && req_bus.valid && req_bus.ready) begin
			ops_sent <= ops_sent + 1;
			if (req_bus.func == FUNC_ALLOC) begin
				want = allocate(req_bus.req_size);
				if (want.status == ST_OK)
					live_grants.push_back(want.granted_addr);
			end else begin
				want = release_block(req_bus.user_addr);
				if (want.status == ST_OK)
					foreach (live_grants[i])
						if (live_grants[i] == req_bus.user_addr) begin
							live_grants.delete(i);
							break;
						end
			end
			expected_outcomes.push_back(want);
		end
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got.status = rsp_bus.status;
			got.granted_addr = rsp_bus.granted_addr;
			got.free_bytes = rsp_bus.free_bytes;
			outcomes_seen <= outcomes_seen + 1;
			if (got.status == ST_OK)
				oks <= oks + 1;
			if (expected_outcomes.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected beat: status %0d addr %0d free %0d",
						got.status, got.granted_addr, got.free_bytes);
			end else begin
				want = expected_outcomes.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: exp st %0d addr %0d free %0d, got st %0d addr %0d free %0d",
							want.status, want.granted_addr, want.free_bytes,
							got.status, got.granted_addr, got.free_bytes);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		if (idx == CFG_FIT_MODE)
			mode = val[1:0];
		else if (idx == CFG_POOL_SIZE) begin
			pool = val;
			pool_reset();
		end
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_ops.size() > 0 || req_bus.valid || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (2 * NCH + 20) @(posedge clk);
	endtask

	function automatic void push_op(logic f, logic [15:0] n, logic [15:0] ua);
		op_t o;
		o.func = f;
		o.req_size = n;
		o.user_addr = ua;
		pending_ops.push_back(o);
	endfunction

	// sizes mostly small so the tables fill and fragment
	function automatic logic [15:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 16'($urandom_range(40));
		if (r < 90)
			return 16'($urandom_range(400));
		return 16'($urandom);
	endfunction

	// random phase: allocate and free in the driver's order; frees target
	// arbitrary addresses, mostly multiples of 8 from 8 to 488, not checked to be live
	function automatic void random_phase(int count);
		for (int k = 0; k < count; k++) begin
			int r;
			r = $urandom_range(99);
			if (r < 50)
				push_op(FUNC_ALLOC, pick_size(), 16'($urandom));
			else if (r < 90)
				push_op(FUNC_FREE, 16'($urandom), 16'(8 + 8 * $urandom_range(60)));
			else
				push_op(FUNC_FREE, 16'($urandom), 16'($urandom));
		end
	endfunction

	task automatic run_phase(int count, int s_idle, int r_stall);
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 55 || live_grants.size() == 0)
				push_op(FUNC_ALLOC, pick_size(), 16'($urandom));
			else if ($urandom_range(9) == 0)
				random_phase(1);
			else
				push_op(FUNC_FREE, 16'($urandom),
					live_grants[$urandom_range(live_grants.size() - 1)]);
			// let the prediction catch up so live_grants reflects what is live
			while (pending_ops.size() > 0 || req_bus.valid)
				@(posedge clk);
		end
		drain();
	endtask

	initial begin
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_FIT_MODE;
		cfg_bus.data = '0;
		mode = FIT_FIRST;
		pool = POOL_RESET;
		pool_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset state, extremes, every policy, error cases
		push_op(FUNC_FREE, 16'hFFFF, 16'd0);
		push_op(FUNC_FREE, 16'h0000, 16'hFFFF);
		push_op(FUNC_ALLOC, 16'hFFFF, 16'h0000);
		push_op(FUNC_ALLOC, 16'd0, 16'hFFFF);
		push_op(FUNC_ALLOC, 16'd100, 16'd0);
		push_op(FUNC_ALLOC, 16'd200, 16'd0);
		push_op(FUNC_ALLOC, 16'd50, 16'd0);
		push_op(FUNC_FREE, 16'd0, 16'd8);
		push_op(FUNC_FREE, 16'd0, 16'd124);
		push_op(FUNC_FREE, 16'd0, 16'd8);
		push_op(FUNC_FREE, 16'd0, 16'd116);
		drain();
		// exact fit: remainder of 8 or less hands over the whole chunk
		write_reg(CFG_POOL_SIZE, 16'd40);
		push_op(FUNC_ALLOC, 16'd26, 16'd0);
		push_op(FUNC_FREE, 16'd0, 16'd8);
		push_op(FUNC_ALLOC, 16'd24, 16'd0);
		push_op(FUNC_ALLOC, 16'd0, 16'd0);
		drain();
		// tiny pool below sixteen
		write_reg(CFG_POOL_SIZE, 16'd7);
		push_op(FUNC_ALLOC, 16'd0, 16'd0);
		drain();
		write_reg(CFG_POOL_SIZE, 16'd16);
		push_op(FUNC_ALLOC, 16'd8, 16'd0);
		drain();
		// worst fit fails if largest does not fit; mode 3 acts as first fit
		for (int m = 0; m < 4; m++) begin
			write_reg(CFG_FIT_MODE, 16'(m));
			write_reg(CFG_POOL_SIZE, 16'hFFFF);
			for (int k = 0; k < 18; k++)
				push_op(FUNC_ALLOC, 16'(8 * (k % 5)), 16'd0);
			for (int k = 0; k < 18; k += 2)
				push_op(FUNC_FREE, 16'd0, 16'(8 + 16 * k));
			push_op(FUNC_ALLOC, 16'd20, 16'd0);
			drain();
		end

		// random phases across policies, pool sizes and idling profiles
		write_reg(CFG_FIT_MODE, 16'(FIT_BEST));
		write_reg(CFG_POOL_SIZE, 16'd4096);
		run_phase(250, 0, 0);
		write_reg(CFG_FIT_MODE, 16'(FIT_WORST));
		write_reg(CFG_POOL_SIZE, 16'd600);
		run_phase(250, 62, 0);
		write_reg(CFG_FIT_MODE, 16'(FIT_FIRST));
		write_reg(CFG_POOL_SIZE, 16'd1000);
		run_phase(250, 0, 62);
		write_reg(CFG_FIT_MODE, 16'd3);
		write_reg(CFG_POOL_SIZE, 16'hFFFF);
		run_phase(150, 7, 7);
		write_reg(CFG_FIT_MODE, 16'(FIT_BEST));
		write_reg(CFG_POOL_SIZE, 16'd16);
		random_phase(60);
		send_idle_pct = 30;
		recv_stall_pct = 30;
		drain();

		$display("%0d operations sent, %0d results checked, %0d granted or freed",
			ops_sent, outcomes_seen, oks);
		$display("covered all fit policies, pool resizes, table-full and bad-address cases");
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[fit_policy_segment_allocator_unit.f]
+incdir+hw/rtl
hw/rtl/fpsa_pkg.sv
hw/rtl/fpsa_if.sv
hw/rtl/fpsa_ram.sv
hw/rtl/fpsa_ctrl.sv
hw/rtl/fpsa_dp.sv
hw/rtl/fit_policy_segment_allocator_unit.sv
hw/rtl/fpsa_checker.sv
tb/sv/fit_policy_segment_allocator_unit_tb.sv
